FILE: rtl/bst_pkg.sv
// Shared types, codes and helpers of the bencode stream tokenizer.
// Used by every module under rtl; depends on nothing else.
package bst_pkg;

	// Character codes of the encoding
	localparam logic [7:0] CHR_I     = 8'h69; // 'i'
	localparam logic [7:0] CHR_L     = 8'h6C; // 'l'
	localparam logic [7:0] CHR_D     = 8'h64; // 'd'
	localparam logic [7:0] CHR_E     = 8'h65; // 'e'
	localparam logic [7:0] CHR_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CHR_COLON = 8'h3A; // ':'
	localparam logic [7:0] CHR_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CHR_NINE  = 8'h39; // '9'

	// Depth of the queue between the front and back parts, and its pointer width
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [2:0] {
		CH_OTHER,
		CH_DIGIT,
		CH_I,
		CH_L,
		CH_D,
		CH_E,
		CH_MINUS,
		CH_COLON
	} chr_t;

	typedef enum logic [2:0] {
		TK_INT,
		TK_STR_START,
		TK_STR_BYTE,
		TK_LIST_OPEN,
		TK_DICT_OPEN,
		TK_CLOSE,
		TK_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_BAD_TYPE,
		ERR_KEY_NOT_STR,
		ERR_BAD_INT,
		ERR_OVERFLOW,
		ERR_EARLY_END,
		ERR_TOO_DEEP
	} err_t;

	typedef enum logic [1:0] {
		MODE_VALUE,
		MODE_INT,
		MODE_LEN,
		MODE_BODY
	} mode_t;

	// Stack entry: list, dict awaiting key, dict awaiting value; NONE when empty
	typedef enum logic [1:0] {
		ENT_LIST,
		ENT_KEY,
		ENT_VAL,
		ENT_NONE
	} ent_t;

	typedef enum logic [3:0] {
		ACT_DROP,
		ACT_FAIL,
		ACT_ACC,
		ACT_NEG,
		ACT_INT_START,
		ACT_INT_DONE,
		ACT_LEN_START,
		ACT_STR_HEAD,
		ACT_STR_EMPTY,
		ACT_STR_BYTE,
		ACT_STR_LAST,
		ACT_PUSH,
		ACT_POP,
		ACT_END,
		ACT_END_ERR
	} act_t;

	// One classified input beat
	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
		chr_t       cls;
		logic [3:0] digit;
	} item_t;

	// One result beat
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [4:0]  nest;
		logic        key;
		logic        done;
		err_t        code;
	} token_t;

	// A value has completed inside a container: flip key/value in a dict
	function automatic ent_t ent_finish(input ent_t e);
		ent_t r;
		unique case (e)
			ENT_KEY: r = ENT_VAL;
			ENT_VAL: r = ENT_KEY;
			default: r = e;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/bst_front.sv
// Front part of the bencode tokenizer: accepts input beats and classifies each byte.
// Depends on bst_pkg.
module bst_front
	import bst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_cmd,
	input  logic [7:0] in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output item_t      out_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	always_comb begin
		item_d.cmd   = in_cmd;
		item_d.data  = in_data;
		item_d.digit = in_data[3:0];
		if (in_data >= CHR_ZERO && in_data <= CHR_NINE) begin
			item_d.cls = CH_DIGIT;
		end else begin
			unique case (in_data)
				CHR_I:     item_d.cls = CH_I;
				CHR_L:     item_d.cls = CH_L;
				CHR_D:     item_d.cls = CH_D;
				CHR_E:     item_d.cls = CH_E;
				CHR_MINUS: item_d.cls = CH_MINUS;
				CHR_COLON: item_d.cls = CH_COLON;
				default:   item_d.cls = CH_OTHER;
			endcase
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

FILE: rtl/bst_fifo.sv
// Short queue of classified beats between the front and back parts.
// Depends on bst_pkg.
module bst_fifo
	import bst_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           pop;

	assign in_ready  = count_q != (QAW+1)'(QDEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

FILE: rtl/bst_back.sv
// Back part of the bencode tokenizer: parse state, nesting stack and token register.
// Depends on bst_pkg.
module bst_back
	import bst_pkg::*;
#(
	parameter int MAX_NEST = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  item_t  in_item,
	output logic   out_valid,
	input  logic   out_ready,
	output token_t out_token
);

	localparam int DW = $clog2(MAX_NEST + 1);

	mode_t          mode_q, mode_d;
	logic [DW-1:0]  depth_q, depth_d;
	logic [31:0]    accum_q, accum_d;
	logic           neg_q, neg_d;
	logic           seen_q, seen_d;
	logic [30:0]    remain_q, remain_d;
	logic           err_q, err_d;
	ent_t           stack_q [MAX_NEST];
	logic           tvalid_q;
	token_t         token_q;

	act_t           act;
	err_t           fail_code;
	ent_t           top;
	ent_t           below_top;
	logic [34:0]    acc_next;
	logic [34:0]    int_limit;
	logic [30:0]    remain_dec;
	logic           fire;
	logic           emit;
	logic           push_en, pop_en, fin_en;
	ent_t           push_ent;
	token_t         token_d;
	logic [DW+4:0]  nest_ext;

	assign in_ready   = !tvalid_q || out_ready;
	assign fire       = in_valid && in_ready;
	assign out_valid  = tvalid_q;
	assign out_token  = token_q;

	assign top        = (depth_q == '0) ? ENT_NONE : stack_q[0];
	assign acc_next   = ({3'b0, accum_q} << 3) + ({3'b0, accum_q} << 1) + 35'(in_item.digit);
	assign int_limit  = neg_q ? 35'h0_8000_0000 : 35'h0_7FFF_FFFF;
	assign remain_dec = remain_q - 31'd1;
	assign nest_ext   = {5'b0, depth_d};

	generate
		if (MAX_NEST > 1) begin : g_below
			assign below_top = stack_q[1];
		end else begin : g_single
			assign below_top = stack_q[0];
		end
	endgenerate

	// Decode: pick the action for the beat at the head of the queue
	always_comb begin
		act       = ACT_DROP;
		fail_code = ERR_NONE;
		if (in_item.cmd) begin
			act = (!err_q && (mode_q != MODE_VALUE || depth_q != '0)) ? ACT_END_ERR : ACT_END;
		end else if (!err_q) begin
			unique case (mode_q)
				MODE_INT: begin
					unique case (in_item.cls)
						CH_DIGIT: begin
							if (seen_q && accum_q == '0) begin
								act = ACT_FAIL; fail_code = ERR_BAD_INT;
							end else if (acc_next > int_limit) begin
								act = ACT_FAIL; fail_code = ERR_OVERFLOW;
							end else begin
								act = ACT_ACC;
							end
						end
						CH_MINUS: begin
							if (seen_q || neg_q) begin
								act = ACT_FAIL; fail_code = ERR_BAD_INT;
							end else begin
								act = ACT_NEG;
							end
						end
						CH_E: begin
							if (!seen_q || (neg_q && accum_q == '0)) begin
								act = ACT_FAIL; fail_code = ERR_BAD_INT;
							end else begin
								act = ACT_INT_DONE;
							end
						end
						default: begin
							act = ACT_FAIL; fail_code = ERR_BAD_INT;
						end
					endcase
				end
				MODE_LEN: begin
					unique case (in_item.cls)
						CH_DIGIT: begin
							if (acc_next > 35'h0_7FFF_FFFF) begin
								act = ACT_FAIL; fail_code = ERR_OVERFLOW;
							end else begin
								act = ACT_ACC;
							end
						end
						CH_COLON: act = (accum_q == '0) ? ACT_STR_EMPTY : ACT_STR_HEAD;
						default: begin
							act = ACT_FAIL; fail_code = ERR_BAD_INT;
						end
					endcase
				end
				MODE_BODY: act = (remain_dec == '0) ? ACT_STR_LAST : ACT_STR_BYTE;
				default: begin
					if (top == ENT_KEY && in_item.cls != CH_E && in_item.cls != CH_DIGIT) begin
						act = ACT_FAIL; fail_code = ERR_KEY_NOT_STR;
					end else begin
						unique case (in_item.cls)
							CH_DIGIT: act = ACT_LEN_START;
							CH_I:     act = ACT_INT_START;
							CH_L, CH_D: begin
								if (depth_q >= DW'(MAX_NEST)) begin
									act = ACT_FAIL; fail_code = ERR_TOO_DEEP;
								end else begin
									act = ACT_PUSH;
								end
							end
							CH_E: begin
								if (top == ENT_LIST || top == ENT_KEY) begin
									act = ACT_POP;
								end else begin
									act = ACT_FAIL; fail_code = ERR_BAD_TYPE;
								end
							end
							default: begin
								act = ACT_FAIL; fail_code = ERR_BAD_TYPE;
							end
						endcase
					end
				end
			endcase
		end
	end

	// Next parse mode
	always_comb begin
		unique case (act)
			ACT_END, ACT_END_ERR, ACT_INT_DONE, ACT_STR_EMPTY,
			ACT_STR_LAST, ACT_PUSH, ACT_POP: mode_d = MODE_VALUE;
			ACT_LEN_START:                   mode_d = MODE_LEN;
			ACT_INT_START:                   mode_d = MODE_INT;
			ACT_STR_HEAD:                    mode_d = MODE_BODY;
			default:                         mode_d = mode_q;
		endcase
	end

	// Datapath and token
	always_comb begin
		depth_d  = depth_q;
		accum_d  = accum_q;
		neg_d    = neg_q;
		seen_d   = seen_q;
		remain_d = remain_q;
		err_d    = err_q;
		push_en  = 1'b0;
		pop_en   = 1'b0;
		fin_en   = 1'b0;
		push_ent = (in_item.cls == CH_L) ? ENT_LIST : ENT_KEY;
		emit     = 1'b0;

		token_d.kind  = TK_ERROR;
		token_d.value = '0;
		token_d.key   = 1'b0;
		token_d.done  = 1'b0;
		token_d.code  = ERR_NONE;

		unique case (act)
			ACT_END, ACT_END_ERR: begin
				depth_d  = '0;
				accum_d  = '0;
				neg_d    = 1'b0;
				seen_d   = 1'b0;
				remain_d = '0;
				err_d    = 1'b0;
				emit     = act == ACT_END_ERR;
				token_d.code = ERR_EARLY_END;
			end
			ACT_FAIL: begin
				err_d        = 1'b1;
				emit         = 1'b1;
				token_d.code = fail_code;
			end
			ACT_ACC: begin
				accum_d = acc_next[31:0];
				seen_d  = seen_q | (mode_q == MODE_INT);
			end
			ACT_NEG: neg_d = 1'b1;
			ACT_INT_START: begin
				accum_d = '0;
				neg_d   = 1'b0;
				seen_d  = 1'b0;
			end
			ACT_INT_DONE: begin
				accum_d       = '0;
				neg_d         = 1'b0;
				seen_d        = 1'b0;
				fin_en        = 1'b1;
				emit          = 1'b1;
				token_d.kind  = TK_INT;
				token_d.value = neg_q ? (32'd0 - accum_q) : accum_q;
				token_d.done  = depth_q == '0;
			end
			ACT_LEN_START: accum_d = {28'b0, in_item.digit};
			ACT_STR_HEAD: begin
				accum_d       = '0;
				remain_d      = accum_q[30:0];
				emit          = 1'b1;
				token_d.kind  = TK_STR_START;
				token_d.value = accum_q;
				token_d.key   = top == ENT_KEY;
			end
			ACT_STR_EMPTY: begin
				accum_d      = '0;
				fin_en       = 1'b1;
				emit         = 1'b1;
				token_d.kind = TK_STR_START;
				token_d.key  = top == ENT_KEY;
				token_d.done = depth_q == '0;
			end
			ACT_STR_BYTE, ACT_STR_LAST: begin
				remain_d      = remain_dec;
				fin_en        = act == ACT_STR_LAST;
				emit          = 1'b1;
				token_d.kind  = TK_STR_BYTE;
				token_d.value = {24'b0, in_item.data};
				token_d.key   = top == ENT_KEY;
				token_d.done  = (act == ACT_STR_LAST) && (depth_q == '0);
			end
			ACT_PUSH: begin
				depth_d      = depth_q + 1'b1;
				push_en      = 1'b1;
				emit         = 1'b1;
				token_d.kind = (in_item.cls == CH_L) ? TK_LIST_OPEN : TK_DICT_OPEN;
			end
			ACT_POP: begin
				depth_d      = depth_q - 1'b1;
				pop_en       = 1'b1;
				emit         = 1'b1;
				token_d.kind = TK_CLOSE;
				token_d.done = depth_d == '0;
			end
			default: ;
		endcase
		token_d.nest = nest_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_VALUE;
			depth_q  <= '0;
			accum_q  <= '0;
			neg_q    <= 1'b0;
			seen_q   <= 1'b0;
			remain_q <= '0;
			err_q    <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			if (fire) begin
				mode_q   <= mode_d;
				depth_q  <= depth_d;
				accum_q  <= accum_d;
				neg_q    <= neg_d;
				seen_q   <= seen_d;
				remain_q <= remain_d;
				err_q    <= err_d;
			end
			if (fire && emit) begin
				tvalid_q <= 1'b1;
			end else if (out_ready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			token_q <= token_d;
		end
	end

	// Nesting stack as a shift line: entry 0 holds the innermost container whenever the depth is nonzero
	always_ff @(posedge clk) begin
		if (fire) begin
			if (push_en) begin
				stack_q[0] <= push_ent;
				for (int i = 1; i < MAX_NEST; i++) begin
					stack_q[i] <= stack_q[i-1];
				end
			end else if (pop_en) begin
				stack_q[0] <= ent_finish(below_top);
				for (int i = 1; i < MAX_NEST - 1; i++) begin
					stack_q[i] <= stack_q[i+1];
				end
			end else if (fin_en) begin
				stack_q[0] <= ent_finish(stack_q[0]);
			end
		end
	end

endmodule

FILE: rtl/bencode_stream_tokenizer_unit.sv
// Top level of the bencode stream tokenizer: front classifier, queue and parser back end.
// Depends on bst_pkg, bst_front, bst_fifo and bst_back.
//
// Usage: feed the encoded stream on the s_axis channel, one byte per beat in s_axis_tdata
// with s_axis_tuser low; a beat with s_axis_tuser high ends the input buffer and clears the
// parser. Tokens leave on m_axis: kind and dict-key flag in tuser, value, nesting depth and
// error code in tdata, and tlast set on the token that completes a top-level value.
// Bytes that produce no token (digits of a number, the 'i' prefix and so on) are absorbed.
// Path: a byte's beat is registered in the classifier stage, then written into the queue, and
// its token is then loaded from the queue head into the token register. Throughput: one byte
// per cycle while m_axis is not stalled; the parser back end handles one byte a cycle while
// its token register is empty or being taken, with the multiply-by-ten accumulate as its longest path.
// Reset clears the parse mode, depth, number and error state; the nesting stack needs no
// clearing since only entries pushed since the last reset or end beat are ever read.
// When the receiver stalls, the token register holds its beat, the back end stops, the
// queue fills, and s_axis_tready drops once the queue and classifier stage are full.
// Errors are reported by a single error token and then stick until an end beat; an end beat
// that arrives mid-value without a prior error answers with an early-end error token.
module bencode_stream_tokenizer_unit
	import bst_pkg::*;
#(
	parameter int MAX_NEST = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] token_value, [36:32] nest_level, [39:37] error_code
	output logic [3:0]  m_axis_tuser,  // [2:0] token_kind, [3] is_dict_key
	output logic        m_axis_tlast   // top_done
);

	logic   front_valid;
	logic   front_ready;
	item_t  front_item;
	logic   queue_valid;
	logic   queue_ready;
	item_t  queue_item;
	token_t token;

	// Classify each byte and hold it for one stage
	bst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	// Decouple the classifier from the parser so either side may stall
	bst_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (queue_valid),
		.out_ready (queue_ready),
		.out_item  (queue_item)
	);

	// Parse state, nesting stack and output token register
	bst_back #(
		.MAX_NEST (MAX_NEST)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (queue_valid),
		.in_ready  (queue_ready),
		.in_item   (queue_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_token (token)
	);

	// Pack the token onto the master beat
	assign m_axis_tdata = {token.code, token.nest, token.value};
	assign m_axis_tuser = {token.key, token.kind};
	assign m_axis_tlast = token.done;

endmodule
